@@ src/kwm_pkg.sv @@
// Shared types, widths and codes for the k-way sorted merge engine.
`timescale 1ns / 1ps

package kwm_pkg;

  localparam int VALUE_W        = 32;
  localparam int LANE_IN_W      = 3;
  localparam int NUM_LISTS_DEF  = 8;
  localparam int LANE_DEPTH_DEF = 64;

  typedef logic signed [VALUE_W-1:0] value_t;
  typedef logic [LANE_IN_W-1:0]      lane_in_t;

  localparam logic MODE_APPEND = 1'b0;
  localparam logic MODE_PULL   = 1'b1;

endpackage

@@ src/kwm_if.sv @@
// Valid/ready channel interfaces for the merge engine's input and result sides.
`timescale 1ns / 1ps

interface kwm_in_if import kwm_pkg::*; ();
  logic     valid;
  logic     ready;
  logic     mode;
  lane_in_t lane;
  value_t   value;

  modport source (output valid, output mode, output lane, output value, input ready);
  modport sink   (input valid, input mode, input lane, input value, output ready);
endinterface

interface kwm_out_if import kwm_pkg::*; ();
  logic   valid;
  logic   ready;
  value_t merged_value;
  logic   delivered;
  logic   all_empty;
  logic   lane_full;

  modport source (output valid, output merged_value, output delivered, output all_empty,
                  output lane_full, input ready);
  modport sink   (input valid, input merged_value, input delivered, input all_empty,
                  input lane_full, output ready);
endinterface

@@ src/kwm_lane_store.sv @@
// Lane queue storage: one write port and one registered read port.
`timescale 1ns / 1ps

module kwm_lane_store import kwm_pkg::*; #(
  parameter int ADDR_W = 9
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  value_t            wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output value_t            rd_data
);

  value_t mem [1 << ADDR_W];
  value_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

@@ src/kwm_min_tree.sv @@
// Comparator tree that picks the smallest valid lane head, lowest lane on ties.
`timescale 1ns / 1ps

module kwm_min_tree import kwm_pkg::*; #(
  parameter int N     = 8,
  parameter int IDX_W = 3
) (
  input  logic [N-1:0]     leaf_vld,
  input  value_t           leaf_val [N],
  output logic             best_vld,
  output logic [IDX_W-1:0] best_idx,
  output value_t           best_val
);

  localparam int P     = 1 << IDX_W;
  localparam int NODES = 2 * P - 1;

  logic             nd_vld [NODES];
  logic [IDX_W-1:0] nd_idx [NODES];
  value_t           nd_val [NODES];

  for (genvar i = 0; i < P; i++) begin : g_leaf
    if (i < N) begin : g_used
      assign nd_vld[P-1+i] = leaf_vld[i];
      assign nd_val[P-1+i] = leaf_val[i];
    end else begin : g_pad
      assign nd_vld[P-1+i] = 1'b0;
      assign nd_val[P-1+i] = '0;
    end
    assign nd_idx[P-1+i] = IDX_W'(i);
  end

  for (genvar n = 0; n < P - 1; n++) begin : g_node
    logic take_r;
    assign take_r = nd_vld[2*n+2] &&
                    (!nd_vld[2*n+1] || (nd_val[2*n+2] < nd_val[2*n+1]));
    assign nd_vld[n] = nd_vld[2*n+1] || nd_vld[2*n+2];
    assign nd_idx[n] = take_r ? nd_idx[2*n+2] : nd_idx[2*n+1];
    assign nd_val[n] = take_r ? nd_val[2*n+2] : nd_val[2*n+1];
  end

  assign best_vld = nd_vld[0];
  assign best_idx = nd_idx[0];
  assign best_val = nd_val[0];

endmodule

@@ src/k_way_sorted_merge_top.sv @@
// Top level of the k-way sorted merge engine with per-lane queues and cached heads.
// A transaction moves from the stage register to the result register when the stage advances.
// Throughput: one transaction per cycle unless the result side stalls.
// A head refill after a pull uses the single registered read port of the lane store and is forwarded from it.
// Reset is synchronous and clears counts, pointers and valid flags.
// The lane store itself is not cleared; only counted entries are ever read.
`timescale 1ns / 1ps

module k_way_sorted_merge_top import kwm_pkg::*; #(
  parameter int NUM_LISTS  = NUM_LISTS_DEF,
  parameter int LANE_DEPTH = LANE_DEPTH_DEF
) (
  input logic        clk,
  input logic        rst_n,
  kwm_in_if.sink     in_chan,
  kwm_out_if.source  out_chan
);

  localparam int LaneW = $clog2(NUM_LISTS);
  localparam int PtrW  = $clog2(LANE_DEPTH);
  localparam int CntW  = $clog2(LANE_DEPTH + 1);
  localparam int AddrW = LaneW + PtrW;

  logic             stg_vld_r;
  logic             stg_mode_r;
  lane_in_t         stg_lane_r;
  value_t           stg_value_r;

  logic             out_vld_r;
  value_t           out_val_r;
  logic             out_dlv_r;
  logic             out_emp_r;
  logic             out_full_r;

  logic [PtrW-1:0]  head_ptr_r [NUM_LISTS];
  logic [PtrW-1:0]  tail_ptr_r [NUM_LISTS];
  logic [CntW-1:0]  cnt_r      [NUM_LISTS];
  value_t           head_val_r [NUM_LISTS];
  logic             rf_pend_r;
  logic [LaneW-1:0] rf_lane_r;

  logic             advance;
  logic             in_take;
  logic             is_pull;
  logic             lane_ok;
  logic [LaneW-1:0] lane_idx;
  logic [LaneW-1:0] sel_idx;
  logic [CntW-1:0]  sel_cnt;
  logic [PtrW-1:0]  sel_head;
  logic [PtrW-1:0]  sel_tail;
  logic [PtrW-1:0]  head_ptr_nxt;
  logic [PtrW-1:0]  tail_ptr_nxt;
  logic             app_ok;
  logic             pull_ok;
  logic             rd_en;
  value_t           rd_data;

  logic [NUM_LISTS-1:0] leaf_vld;
  value_t               leaf_val [NUM_LISTS];
  logic                 best_vld;
  logic [LaneW-1:0]     best_idx;
  value_t               best_val;

  assign advance        = stg_vld_r && (!out_vld_r || out_chan.ready);
  assign in_chan.ready  = !stg_vld_r || advance;
  assign in_take        = in_chan.valid && in_chan.ready;

  assign is_pull  = (stg_mode_r == MODE_PULL);
  assign lane_idx = LaneW'(stg_lane_r);
  assign lane_ok  = int'(stg_lane_r) < NUM_LISTS;

  for (genvar i = 0; i < NUM_LISTS; i++) begin : g_lane
    assign leaf_vld[i] = (cnt_r[i] != '0);
    assign leaf_val[i] = (rf_pend_r && (rf_lane_r == LaneW'(i))) ? rd_data : head_val_r[i];
  end

  kwm_min_tree #(
    .N     (NUM_LISTS),
    .IDX_W (LaneW)
  ) u_min_tree (
    .leaf_vld (leaf_vld),
    .leaf_val (leaf_val),
    .best_vld (best_vld),
    .best_idx (best_idx),
    .best_val (best_val)
  );

  assign sel_idx  = is_pull ? best_idx : lane_idx;
  assign sel_cnt  = cnt_r[sel_idx];
  assign sel_head = head_ptr_r[sel_idx];
  assign sel_tail = tail_ptr_r[sel_idx];

  assign head_ptr_nxt = (sel_head == PtrW'(LANE_DEPTH - 1)) ? '0 : sel_head + 1'b1;
  assign tail_ptr_nxt = (sel_tail == PtrW'(LANE_DEPTH - 1)) ? '0 : sel_tail + 1'b1;

  assign app_ok  = !is_pull && lane_ok && (sel_cnt < CntW'(LANE_DEPTH));
  assign pull_ok = is_pull && best_vld;
  assign rd_en   = advance && pull_ok && (sel_cnt != CntW'(1));

  kwm_lane_store #(
    .ADDR_W (AddrW)
  ) u_lane_store (
    .clk     (clk),
    .wr_en   (advance && app_ok),
    .wr_addr ({lane_idx, sel_tail}),
    .wr_data (stg_value_r),
    .rd_en   (rd_en),
    .rd_addr ({best_idx, head_ptr_nxt}),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_vld_r <= 1'b0;
      out_vld_r <= 1'b0;
      rf_pend_r <= 1'b0;
      for (int i = 0; i < NUM_LISTS; i++) begin
        head_ptr_r[i] <= '0;
        tail_ptr_r[i] <= '0;
        cnt_r[i]      <= '0;
      end
    end else begin
      if (in_take) begin
        stg_vld_r <= 1'b1;
      end else if (advance) begin
        stg_vld_r <= 1'b0;
      end
      if (advance) begin
        out_vld_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_vld_r <= 1'b0;
      end
      rf_pend_r <= rd_en;
      if (advance && app_ok) begin
        cnt_r[lane_idx]      <= sel_cnt + 1'b1;
        tail_ptr_r[lane_idx] <= tail_ptr_nxt;
      end
      if (advance && pull_ok) begin
        cnt_r[best_idx]      <= sel_cnt - 1'b1;
        head_ptr_r[best_idx] <= head_ptr_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      stg_mode_r  <= in_chan.mode;
      stg_lane_r  <= in_chan.lane;
      stg_value_r <= in_chan.value;
    end
    if (rd_en) begin
      rf_lane_r <= best_idx;
    end
    if (rf_pend_r) begin
      head_val_r[rf_lane_r] <= rd_data;
    end
    if (advance && app_ok && (sel_cnt == '0)) begin
      head_val_r[lane_idx] <= stg_value_r;
    end
    if (advance) begin
      out_val_r  <= pull_ok ? best_val : '0;
      out_dlv_r  <= pull_ok;
      out_emp_r  <= is_pull && !best_vld;
      out_full_r <= !is_pull && !app_ok;
    end
  end

  assign out_chan.valid        = out_vld_r;
  assign out_chan.merged_value = out_val_r;
  assign out_chan.delivered    = out_dlv_r;
  assign out_chan.all_empty    = out_emp_r;
  assign out_chan.lane_full    = out_full_r;

endmodule

@@ src/kwm_checker.sv @@
// Port-level assertions for the merge engine and the bind that attaches them.
`timescale 1ns / 1ps

module kwm_checker import kwm_pkg::*; (
  input logic   clk,
  input logic   rst_n,
  input logic   out_valid,
  input logic   out_ready,
  input value_t out_merged_value,
  input logic   out_delivered,
  input logic   out_all_empty,
  input logic   out_lane_full
);

  a_one_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $countones({out_delivered, out_all_empty, out_lane_full}) <= 1)
    else $error("More than one status flag is set on a result transaction.");

  a_value_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_delivered) |-> (out_merged_value == '0))
    else $error("A result without a delivered value carries a nonzero value.");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_merged_value) &&
      $stable(out_delivered) && $stable(out_all_empty) && $stable(out_lane_full)))
    else $error("A stalled result transaction changed or was withdrawn.");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("A result transaction is offered right after reset.");

endmodule

bind k_way_sorted_merge_top kwm_checker u_kwm_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_chan.valid),
  .out_ready        (out_chan.ready),
  .out_merged_value (out_chan.merged_value),
  .out_delivered    (out_chan.delivered),
  .out_all_empty    (out_chan.all_empty),
  .out_lane_full    (out_chan.lane_full)
);
